// ===== design/gf2_16_mul_pow_inv_macros.svh =====
// Assertion macros for the GF(2^16) multiply / power / inverse unit.
// Used by design/gf2_16_mul_pow_inv.sv; define NO_ASSERTIONS to drop them.
`ifndef GF2_16_MUL_POW_INV_MACROS_SVH
`define GF2_16_MUL_POW_INV_MACROS_SVH
`ifndef NO_ASSERTIONS
`define GF16MPI_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gf16mpi assertion failed");
`define GF16MPI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gf16mpi assertion failed");
`else
`define GF16MPI_ASSERT_SAME(lbl, ante, cons)
`define GF16MPI_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== design/gf16mpi_pkg.sv =====
// Shared types, constants and microcode ROM for the GF(2^16) unit.
// No dependencies.
package gf16mpi_pkg;

    localparam int unsigned FieldW = 16;
    localparam int unsigned CntW   = 4;

    localparam logic [FieldW-1:0] INV_EXP  = 16'hFFFE;
    localparam logic [FieldW-1:0] FIELD_ONE = 16'h0001;

    typedef logic [FieldW-1:0] elem_t;
    typedef logic [1:0]        pc_t;

    typedef enum logic [1:0] {
        KIND_MUL  = 2'd0,
        KIND_POW  = 2'd1,
        KIND_INV  = 2'd2,
        KIND_NONE = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        SRC_BASE_EXP,
        SRC_ACC_BASE,
        SRC_BASE_BASE
    } src_t;

    typedef enum logic {
        WACC_NONE,
        WACC_IF_BIT
    } wacc_t;

    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_LOOP,
        JMP_FINISH
    } jmp_t;

    typedef enum logic {
        RES_PROD,
        RES_ACC
    } res_t;

    typedef struct packed {
        src_t  src;
        wacc_t wacc;
        logic  wr_base;
        logic  shift;
        jmp_t  jmp;
        pc_t   target;
        res_t  res;
    } ctrl_t;

    typedef struct packed {
        logic busy;
        logic fin;
    } seq_stat_t;

    localparam pc_t PC_MUL  = 2'd0;
    localparam pc_t PC_POW  = 2'd1;
    localparam pc_t PC_SQR  = 2'd2;
    localparam pc_t PC_END  = 2'd3;

    function automatic ctrl_t ucode_rom(input pc_t pc);
        ctrl_t w;
        w = '{src: SRC_BASE_EXP, wacc: WACC_NONE, wr_base: 1'b0, shift: 1'b0,
              jmp: JMP_FINISH, target: PC_MUL, res: RES_ACC};
        unique case (pc)
            PC_MUL:
            begin
                w.src = SRC_BASE_EXP;
                w.res = RES_PROD;
                w.jmp = JMP_FINISH;
            end
            PC_POW:
            begin
                w.src  = SRC_ACC_BASE;
                w.wacc = WACC_IF_BIT;
                w.jmp  = JMP_NEXT;
            end
            PC_SQR:
            begin
                w.src     = SRC_BASE_BASE;
                w.wr_base = 1'b1;
                w.shift   = 1'b1;
                w.jmp     = JMP_LOOP;
                w.target  = PC_POW;
                w.res     = RES_ACC;
            end
            PC_END:
            begin
                w.res = RES_ACC;
                w.jmp = JMP_FINISH;
            end
            default:
            begin
                w.jmp = JMP_FINISH;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== design/gf16mpi_mul.sv =====
// Combinational GF(2^16) multiplier, polynomial x^16+x^5+x^3+x+1.
// Depends on gf16mpi_pkg.
module gf16mpi_mul (
    input  gf16mpi_pkg::elem_t x,
    input  gf16mpi_pkg::elem_t y,
    output gf16mpi_pkg::elem_t p
);
    import gf16mpi_pkg::*;

    logic [2*FieldW-2:0] prod;
    logic [14:0]         hi;
    logic [19:0]         fold1;
    logic [3:0]          top;
    logic [8:0]          fold2;

    always_comb
    begin
        prod = '0;
        for (int i = 0; i < FieldW; i++)
        begin
            if (y[i])
                prod = prod ^ ({15'd0, x} << i);
        end
    end

    // x^16 == x^5 + x^3 + x + 1, folded twice
    assign hi    = prod[30:16];
    assign fold1 = {5'd0, hi} ^ {4'd0, hi, 1'b0} ^ {2'd0, hi, 3'b0} ^ {hi, 5'b0};
    assign top   = fold1[19:16];
    assign fold2 = {5'd0, top} ^ {4'd0, top, 1'b0} ^ {2'd0, top, 3'b0} ^ {top, 5'b0};
    assign p     = prod[15:0] ^ fold1[15:0] ^ {7'd0, fold2};

endmodule

// ===== design/gf16mpi_seq.sv =====
// Microcode sequencer: step counter, loop counter, control word from ROM.
// Depends on gf16mpi_pkg.
module gf16mpi_seq (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  gf16mpi_pkg::pc_t       entry,
    input  logic                   hold,
    output gf16mpi_pkg::ctrl_t     ctrl,
    output gf16mpi_pkg::seq_stat_t stat
);
    import gf16mpi_pkg::*;

    pc_t             pc_reg,   pc_next;
    logic [CntW-1:0] cnt_reg,  cnt_next;
    logic            busy_reg, busy_next;
    logic            last;

    assign ctrl      = ucode_rom(pc_reg);
    assign last      = (cnt_reg == {CntW{1'b1}});
    assign stat.busy = busy_reg;
    assign stat.fin  = busy_reg &&
                       ((ctrl.jmp == JMP_FINISH) || ((ctrl.jmp == JMP_LOOP) && last));

    always_comb
    begin
        pc_next   = pc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            pc_next   = entry;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg && !hold)
        begin
            unique case (ctrl.jmp)
                JMP_NEXT:
                begin
                    pc_next = pc_reg + 2'd1;
                end
                JMP_LOOP:
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if (last)
                        busy_next = 1'b0;
                    else
                        pc_next = ctrl.target;
                end
                JMP_FINISH:
                begin
                    busy_next = 1'b0;
                end
                default:
                begin
                    busy_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= PC_MUL;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            pc_reg   <= pc_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

endmodule

// ===== design/gf2_16_mul_pow_inv.sv =====
// GF(2^16) multiply / power / inverse unit, one request at a time.
// Multiply and the unused kind finish at their entry microcode word; power and inverse loop
// over every exponent bit. A request is accepted only once the previous one has finished.
// Power and inverse run 32 dependent products through the one shared multiplier.
// Async active-low reset clears control; no request and no result pending after reset.
// Depends on gf16mpi_pkg, gf16mpi_seq, gf16mpi_mul, gf2_16_mul_pow_inv_macros.svh.
module gf2_16_mul_pow_inv (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [15:0] operand_a,
    input  logic [15:0] operand_b,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] result
);
    import gf16mpi_pkg::*;

    `include "gf2_16_mul_pow_inv_macros.svh"

    ctrl_t     ctrl;
    seq_stat_t stat;
    pc_t       entry;
    kind_t     kind_in;
    logic      start;
    logic      hold;
    logic      step;

    elem_t acc_reg,  acc_next;
    elem_t base_reg, base_next;
    elem_t exp_reg,  exp_next;
    elem_t res_reg,  res_next;
    logic  out_valid_reg, out_valid_next;
    elem_t mul_x, mul_y, mul_p;

    assign kind_in  = kind_t'(kind);
    assign in_stall = stat.busy;
    assign start    = in_valid && !stat.busy;
    assign hold     = stat.fin && out_valid_reg && out_stall;
    assign step     = stat.busy && !hold;

    always_comb
    begin
        unique case (kind_in)
            KIND_MUL:  entry = PC_MUL;
            KIND_POW:  entry = PC_POW;
            KIND_INV:  entry = PC_POW;
            KIND_NONE: entry = PC_END;
            default:   entry = PC_END;
        endcase
    end

    gf16mpi_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .entry (entry),
        .hold  (hold),
        .ctrl  (ctrl),
        .stat  (stat)
    );

    always_comb
    begin
        unique case (ctrl.src)
            SRC_BASE_EXP:
            begin
                mul_x = base_reg;
                mul_y = exp_reg;
            end
            SRC_ACC_BASE:
            begin
                mul_x = acc_reg;
                mul_y = base_reg;
            end
            SRC_BASE_BASE:
            begin
                mul_x = base_reg;
                mul_y = base_reg;
            end
            default:
            begin
                mul_x = base_reg;
                mul_y = base_reg;
            end
        endcase
    end

    gf16mpi_mul u_mul (
        .x (mul_x),
        .y (mul_y),
        .p (mul_p)
    );

    always_comb
    begin
        acc_next       = acc_reg;
        base_next      = base_reg;
        exp_next       = exp_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        if (start)
        begin
            base_next = operand_a;
            exp_next  = (kind_in == KIND_INV) ? INV_EXP : operand_b;
            acc_next  = (kind_in == KIND_NONE) ? '0 : FIELD_ONE;
        end
        else if (step)
        begin
            if ((ctrl.wacc == WACC_IF_BIT) && exp_reg[0])
                acc_next = mul_p;
            if (ctrl.wr_base)
                base_next = mul_p;
            if (ctrl.shift)
                exp_next = {1'b0, exp_reg[FieldW-1:1]};
            if (stat.fin)
            begin
                res_next       = (ctrl.res == RES_PROD) ? mul_p : acc_reg;
                out_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        base_reg <= base_next;
        exp_reg  <= exp_next;
        res_reg  <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    assign out_valid = out_valid_reg;
    assign result    = res_reg;

    `GF16MPI_ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, in_stall)
    `GF16MPI_ASSERT_NEXT(a_finish_valid, step && stat.fin, out_valid)
    `GF16MPI_ASSERT_NEXT(a_hold_keeps_busy, hold, in_stall)
    `GF16MPI_ASSERT_SAME(a_no_overwrite, stat.fin && step, !out_valid || !out_stall)

endmodule

// ===== dv/gf2_16_mul_pow_inv_tb.sv =====
// Testbench for gf2_16_mul_pow_inv: directed and random multiply, power and inverse
// requests under idle, stall and long hold-off traffic, checked against a GF(2^16) predictor.
// Depends on gf16mpi_pkg and the gf2_16_mul_pow_inv RTL.
module gf2_16_mul_pow_inv_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gf16mpi_pkg::*;

    localparam logic [16:0] FIELD_POLY  = 17'h1002B;
    localparam int          LIMIT       = 500_000;
    localparam int          HOLD_CYCLES = 300;
    localparam int          TAIL_CYCLES = 40;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic [1:0]  kind      = KIND_MUL;
    logic [15:0] operand_a = '0;
    logic [15:0] operand_b = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [15:0] result;

    elem_t pending_results[$];
    int    errors         = 0;
    int    sender_idle_pct = 0;
    int    stall_pct      = 0;
    int    hold_trigger   = 0;
    int    hold_seen      = 0;
    int    hold_left      = 0;

    gf2_16_mul_pow_inv dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .result    (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic elem_t field_product(input elem_t x, input elem_t y);
        elem_t acc;
        acc = '0;
        for (int i = 0; i < 16; i++)
        begin
            if (y[i])
                acc ^= x;
            x = (x << 1) ^ (x[15] ? FIELD_POLY[15:0] : 16'h0000);
        end
        return acc;
    endfunction

    function automatic elem_t field_power(input elem_t base, input elem_t ex);
        elem_t acc;
        acc = FIELD_ONE;
        for (int i = 0; i < 16; i++)
        begin
            if (ex[i])
                acc = field_product(acc, base);
            base = field_product(base, base);
        end
        return acc;
    endfunction

    function automatic elem_t field_result(input kind_t k, input elem_t a, input elem_t b);
        case (k)
            KIND_MUL: return field_product(a, b);
            KIND_POW: return field_power(a, b);
            KIND_INV: return field_power(a, INV_EXP);
            default:  return '0;
        endcase
    endfunction

    function automatic elem_t pick_element();
        case ($urandom_range(15))
            0:       return 16'h0000;
            1:       return 16'h0001;
            2:       return 16'hFFFF;
            3:       return 16'h8000;
            default: return elem_t'($urandom_range(16'hFFFF));
        endcase
    endfunction

    // One request; valid stays high across back-to-back requests.
    task automatic send_request(input kind_t k, input elem_t a, input elem_t b);
        if ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < sender_idle_pct);
        end
        in_valid  <= 1'b1;
        kind      <= k;
        operand_a <= a;
        operand_b <= b;
        do
            @(posedge clk);
        while (in_stall);
        pending_results.push_back(field_result(k, a, b));
    endtask

    task automatic test_directed_cases();
        send_request(KIND_MUL,  16'h0000, 16'hFFFF);
        send_request(KIND_MUL,  16'h0001, 16'hA5C3);
        send_request(KIND_MUL,  16'hFFFF, 16'hFFFF);
        send_request(KIND_MUL,  16'h8000, 16'h0002);
        send_request(KIND_MUL,  16'h8000, 16'h8000);
        send_request(KIND_POW,  16'h0000, 16'h0000);
        send_request(KIND_POW,  16'hFFFF, 16'h0000);
        send_request(KIND_POW,  16'h0000, 16'h0001);
        send_request(KIND_POW,  16'h1234, 16'h0001);
        send_request(KIND_POW,  16'h0002, 16'hFFFF);
        send_request(KIND_POW,  16'hFFFF, 16'hFFFF);
        send_request(KIND_POW,  16'h0002, 16'h0010);
        send_request(KIND_INV,  16'h0000, 16'h0000);
        send_request(KIND_INV,  16'h0001, 16'hFFFF);
        send_request(KIND_INV,  16'hFFFF, 16'h1234);
        send_request(KIND_INV,  16'h8000, 16'h0000);
        send_request(KIND_INV,  16'h0002, 16'hFFFF);
        send_request(KIND_NONE, 16'hFFFF, 16'hFFFF);
        send_request(KIND_NONE, 16'h0000, 16'h0000);
        send_request(KIND_MUL,  16'h0000, 16'h0000);
    endtask

    task automatic test_random_traffic(input int count, input int idle_pct, input int stall);
        int    sel;
        kind_t k;
        sender_idle_pct = idle_pct;
        stall_pct      <= stall;
        for (int n = 0; n < count; n++)
        begin
            sel = $urandom_range(15);
            if (sel < 5)
                k = KIND_MUL;
            else if (sel < 10)
                k = KIND_POW;
            else if (sel < 14)
                k = KIND_INV;
            else
                k = KIND_NONE;
            send_request(k, pick_element(), pick_element());
        end
    endtask

    // Output held off for a long stretch while requests keep coming.
    task automatic test_output_hold();
        hold_trigger <= hold_trigger + 1;
        test_random_traffic(24, 0, 0);
    endtask

    always @(posedge clk)
    begin
        if (hold_trigger != hold_seen)
        begin
            hold_seen <= hold_trigger;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin : check_results
        elem_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result: unexpected result 0x%h with no request outstanding", result);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result !== want)
                begin
                    $error("result: expected 0x%h, actual 0x%h", want, result);
                    errors++;
                end
            end
        end
    end

    initial
    begin : watchdog
        repeat (LIMIT) @(posedge clk);
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_random_traffic(270, 0, 0);
        test_random_traffic(270, 57, 0);
        test_random_traffic(270, 0, 57);
        test_random_traffic(270, 16, 16);
        test_output_hold();
        test_random_traffic(100, 0, 0);

        in_valid  <= 1'b0;
        stall_pct <= 0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (errors == 0 && pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
